// ===== sv/fbc_pkg.sv =====
package fbc_pkg;

  // cipher mode codes
  localparam logic [1:0] MODE_CBC_ENC = 2'd0;
  localparam logic [1:0] MODE_CBC_DEC = 2'd1;
  localparam logic [1:0] MODE_CFB_ENC = 2'd2;
  localparam logic [1:0] MODE_CFB_DEC = 2'd3;

  // register indexes
  localparam logic [1:0] REG_CIPHER_MODE = 2'd0;
  localparam logic [1:0] REG_BASE_KEY    = 2'd1;
  localparam logic [1:0] REG_ROUND_COUNT = 2'd2;
  localparam logic [1:0] REG_INIT_VECTOR = 2'd3;

  localparam int          DEF_MAX_ROUNDS  = 128;
  localparam logic [7:0]  ROUND_COUNT_RST = 8'd99;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } fbc_state_t;

  // F(x,k) = rotl(x,9) ^ ~(rotr(k,11) ^ x)
  function automatic logic [15:0] fbc_f(input logic [15:0] x, input logic [15:0] k);
    logic [15:0] rl9;
    logic [15:0] rr11;
    rl9  = {x[6:0], x[15:7]};
    rr11 = {k[10:0], k[15:11]};
    return rl9 ^ ~(rr11 ^ x);
  endfunction

  // key j alternates base, swap, swap, base with period four
  function automatic logic [15:0] fbc_key(input logic [15:0] base, input logic [1:0] idx_lo);
    logic [15:0] k;
    k = (idx_lo[0] ^ idx_lo[1]) ? {base[7:0], base[15:8]} : base;
    return k;
  endfunction

endpackage

// ===== sv/fbc_round.sv =====
module fbc_round
  import fbc_pkg::*;
(
  input  logic [63:0] blk_in,
  input  logic [15:0] round_key,
  input  logic        dec,
  output logic [63:0] blk_out
);

  logic [15:0] w0, w1, w2, w3;
  logic [15:0] t;

  assign w0 = blk_in[15:0];
  assign w1 = blk_in[31:16];
  assign w2 = blk_in[47:32];
  assign w3 = blk_in[63:48];

  // one round function shared by both directions
  assign t = fbc_f(dec ? w3 : w0, round_key);

  always_comb begin
    if (dec) begin
      blk_out = {t ^ w2, t ^ w1, t ^ w0, w3};
    end else begin
      blk_out = {w0, t ^ w3, t ^ w2, t ^ w1};
    end
  end

endmodule

// ===== sv/feistel4_block_cipher_cbc_cfb.sv =====
// Four-branch Feistel block cipher with CBC / CFB chaining.
// Input channel (in_*): one 64-bit block per beat in in_tdata, in_tuser
// flags the first block of a message, which then chains from the IV.
// Output channel (out_*): one 64-bit result beat per input beat, in order.
// Config channel (cfg_*): cfg_index selects mode, base key, round count or
// IV; always ready, write only while no block is in flight.
// One shared round unit runs one round per cycle. With n the round count
// (saturated to MAX_ROUNDS) a block is loaded on acceptance, runs n rounds
// and then has its result registered in the output register (out_tvalid).
// The next block is taken only once the previous result is registered;
// in the encrypting modes the chain value is only known at the end.
// A finished result sits in the output register, so the next block is
// taken even while the receiver stalls; if the receiver still holds off
// the second result, the sequencer waits in its done state.
// Synchronous reset clears the chain value, the registers (round count to
// 99) and all valid flags.
module feistel4_block_cipher_cbc_cfb
  import fbc_pkg::*;
#(
  parameter int MAX_ROUNDS = DEF_MAX_ROUNDS
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] data_block
  input  logic        in_tuser,   // [0] restart_chain
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] result_block
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam logic [7:0] MAX_N = 8'(MAX_ROUNDS);

  fbc_state_t  state_r, state_nxt;
  logic [1:0]  mode_r;
  logic [15:0] base_key_r;
  logic [7:0]  round_count_r;
  logic [63:0] iv_r;
  logic [63:0] chain_r, chain_nxt;
  logic [63:0] blk_r, blk_nxt;
  logic [63:0] post_r, post_nxt;
  logic        dec_r, dec_nxt;
  logic        fb_r, fb_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_data_r, out_data_nxt;

  logic        in_acc;
  logic [7:0]  n_sat;
  logic [63:0] chain_in;
  logic [63:0] round_out;
  logic        out_free;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  assign n_sat    = (round_count_r > MAX_N) ? MAX_N : round_count_r;
  assign chain_in = in_tuser ? iv_r : chain_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_CBC_ENC;
      base_key_r    <= '0;
      round_count_r <= ROUND_COUNT_RST;
      iv_r          <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CIPHER_MODE: mode_r        <= cfg_data[1:0];
        REG_BASE_KEY:    base_key_r    <= cfg_data[15:0];
        REG_ROUND_COUNT: round_count_r <= cfg_data[7:0];
        REG_INIT_VECTOR: iv_r          <= cfg_data;
        default: ;
      endcase
    end
  end

  // shared round unit
  fbc_round u_round (
    .blk_in    (blk_r),
    .round_key (fbc_key(base_key_r, idx_r[1:0])),
    .dec       (dec_r),
    .blk_out   (round_out)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chain_r     <= '0;
      out_valid_r <= 1'b0;
      rem_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      chain_r     <= chain_nxt;
      out_valid_r <= out_valid_nxt;
      rem_r       <= rem_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    blk_r      <= blk_nxt;
    post_r     <= post_nxt;
    dec_r      <= dec_nxt;
    fb_r       <= fb_nxt;
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
  end

  // next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    chain_nxt     = chain_r;
    blk_nxt       = blk_r;
    post_nxt      = post_r;
    dec_nxt       = dec_r;
    fb_nxt        = fb_r;
    rem_nxt       = rem_r;
    idx_nxt       = idx_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          rem_nxt   = n_sat;
          state_nxt = (n_sat == 8'd0) ? ST_DONE : ST_RUN;
          unique case (mode_r)
            MODE_CBC_ENC: begin
              blk_nxt  = in_tdata ^ chain_in;
              post_nxt = '0;
              dec_nxt  = 1'b0;
              fb_nxt   = 1'b1;
              idx_nxt  = '0;
            end
            MODE_CBC_DEC: begin
              blk_nxt   = in_tdata;
              post_nxt  = chain_in;
              dec_nxt   = 1'b1;
              fb_nxt    = 1'b0;
              idx_nxt   = n_sat - 8'd1;
              chain_nxt = in_tdata;
            end
            MODE_CFB_ENC: begin
              blk_nxt  = chain_in;
              post_nxt = in_tdata;
              dec_nxt  = 1'b0;
              fb_nxt   = 1'b1;
              idx_nxt  = '0;
            end
            MODE_CFB_DEC: begin
              blk_nxt   = chain_in;
              post_nxt  = in_tdata;
              dec_nxt   = 1'b0;
              fb_nxt    = 1'b0;
              idx_nxt   = '0;
              chain_nxt = in_tdata;
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        // one round per cycle, key index walks up or down
        blk_nxt = round_out;
        rem_nxt = rem_r - 8'd1;
        idx_nxt = dec_r ? idx_r - 8'd1 : idx_r + 8'd1;
        if (rem_r == 8'd1) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // hand result to the output register once it is free
        if (out_free) begin
          out_data_nxt  = blk_r ^ post_r;
          out_valid_nxt = 1'b1;
          if (fb_r) begin
            chain_nxt = blk_r ^ post_r;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // an accepted block always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != ST_IDLE))
    else $error("accepted block did not start");

  // rounds only run with a nonzero remaining count
  a_run_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (rem_r != 8'd0))
    else $error("round sequencer running with zero count");

  // leaving done always presents a result
  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free) |=> out_tvalid)
    else $error("finished block lost");

endmodule

// ===== test/fbc_result_check.sv =====
`timescale 1ns / 1ps

module fbc_result_check
  import fbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] data_block
  input  logic        in_tuser,   // [0] restart_chain
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,  // [63:0] result_block
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          mismatches,
  output int          blocks_pending
);

  // register copies and chaining state
  logic [1:0]  mode_q;
  logic [15:0] key_q;
  logic [7:0]  rounds_q;
  logic [63:0] iv_q;
  logic [63:0] chain_q;

  logic [63:0] expected_blocks [$];

  initial begin
    mismatches     = 0;
    blocks_pending = 0;
  end

  function automatic logic [15:0] rotr16(input logic [15:0] v, input int s);
    return (v >> s) | (v << (16 - s));
  endfunction

  // round function: rotl(x,9) ^ ~(rotr(k,11) ^ x)
  function automatic logic [15:0] round_mix(input logic [15:0] x, input logic [15:0] k);
    return rotr16(x, 7) ^ ~(rotr16(k, 11) ^ x);
  endfunction

  // n rounds forward, or undone in reverse key order
  function automatic logic [63:0] feistel_rounds(input logic [63:0] v,
                                                 input logic [15:0] base,
                                                 input int n, input bit inverse);
    logic [15:0] ks [0:DEF_MAX_ROUNDS-1];
    logic [15:0] w0, w1, w2, w3, t, k;
    int i;
    k = base;
    for (i = 0; i < n; i++) begin
      k = rotr16(k, (8 * i) % 16);
      ks[i] = k;
    end
    {w3, w2, w1, w0} = v;
    if (!inverse) begin
      for (i = 0; i < n; i++) begin
        t = round_mix(w0, ks[i]);
        {w0, w1, w2, w3} = {t ^ w1, t ^ w2, t ^ w3, w0};
      end
    end else begin
      for (i = n - 1; i >= 0; i--) begin
        t = round_mix(w3, ks[i]);
        {w3, w2, w1, w0} = {t ^ w2, t ^ w1, t ^ w0, w3};
      end
    end
    return {w3, w2, w1, w0};
  endfunction

  // work out the result of one accepted block and advance the chain
  task automatic accept_block(input logic [63:0] data, input logic restart);
    logic [63:0] chain_in;
    logic [63:0] result;
    int n;
    chain_in = restart ? iv_q : chain_q;
    n = (rounds_q > DEF_MAX_ROUNDS) ? DEF_MAX_ROUNDS : int'(rounds_q);
    case (mode_q)
      MODE_CBC_ENC: begin
        result  = feistel_rounds(data ^ chain_in, key_q, n, 1'b0);
        chain_q = result;
      end
      MODE_CBC_DEC: begin
        result  = feistel_rounds(data, key_q, n, 1'b1) ^ chain_in;
        chain_q = data;
      end
      MODE_CFB_ENC: begin
        result  = feistel_rounds(chain_in, key_q, n, 1'b0) ^ data;
        chain_q = result;
      end
      default: begin
        result  = feistel_rounds(chain_in, key_q, n, 1'b0) ^ data;
        chain_q = data;
      end
    endcase
    expected_blocks = {expected_blocks, result};
  endtask

  // one line per mismatch
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // watch the three channels at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      mode_q   = MODE_CBC_ENC;
      key_q    = '0;
      rounds_q = ROUND_COUNT_RST;
      iv_q     = '0;
      chain_q  = '0;
      expected_blocks.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CIPHER_MODE: mode_q   = cfg_data[1:0];
          REG_BASE_KEY:    key_q    = cfg_data[15:0];
          REG_ROUND_COUNT: rounds_q = cfg_data[7:0];
          REG_INIT_VECTOR: iv_q     = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        accept_block(in_tdata, in_tuser);
      if (out_tvalid && out_tready) begin
        if (expected_blocks.size() == 0)
          report_mismatch("result beat with nothing expected", out_tdata, '0);
        else if (out_tdata !== expected_blocks[0])
          report_mismatch("result_block", out_tdata, expected_blocks.pop_front());
        else
          void'(expected_blocks.pop_front());
      end
    end
    blocks_pending <= expected_blocks.size();
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import fbc_pkg::*;

  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 140;
  localparam int RANDOM_ITEMS = 800;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // [63:0] data_block
  logic        in_tuser;   // [0] restart_chain
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // [63:0] result_block
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  int mismatches;
  int blocks_pending;
  bit in_beat;
  bit cfg_beat;
  bit hold_results;

  feistel4_block_cipher_cbc_cfb dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  fbc_result_check u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .blocks_pending (blocks_pending)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  // handshakes seen at the rising edge, read by the drivers at the falling edge
  always @(posedge clk) begin
    in_beat  <= in_tvalid && in_tready;
    cfg_beat <= cfg_valid && cfg_ready;
  end

  // result side: stretches of steady ready, short stalls, rare long stalls
  initial begin : receiver
    int  run_left;
    bit  run_ready;
    bit  held;
    int  r;
    out_tready = 1'b0;
    run_left   = 0;
    run_ready  = 1'b0;
    held       = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_results && !held) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        held = 1'b1;
        run_left = 0;
      end else begin
        if (run_left == 0) begin
          r = $urandom_range(0, 99);
          if (r < 50) begin
            run_ready = 1'b1;
            run_left  = $urandom_range(1, 40);
          end else if (r < 90) begin
            run_ready = 1'b0;
            run_left  = $urandom_range(1, 4);
          end else begin
            run_ready = 1'b0;
            run_left  = $urandom_range(10, 60);
          end
        end
        out_tready <= run_ready;
        run_left--;
      end
    end
  end

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45)
      return 0;
    else if (r < 85)
      return $urandom_range(1, 4);
    return $urandom_range(15, 150);
  endfunction

  function automatic logic [63:0] random_block();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)
      return '0;
    else if (r < 10)
      return '1;
    return {$urandom, $urandom};
  endfunction

  // offer one beat, return at the falling edge after it was taken
  task automatic send_block(input logic [63:0] data, input bit restart, input int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= restart;
    do @(negedge clk); while (!in_beat);
  endtask

  // stop offering and wait until every result has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (blocks_pending != 0) @(negedge clk);
  endtask

  // register write; unused upper data bits are driven as the caller gives them
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(negedge clk); while (!cfg_beat);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : stimulus
    int          sent;
    int          phase_len;
    int          i;
    int          r;
    logic [63:0] noise;
    logic [7:0]  rounds;
    logic [15:0] key;

    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_CIPHER_MODE;
    cfg_data     = '0;
    hold_results = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings, first blocks chain from the cleared chain value
    send_block(64'h0, 1'b0, 0);
    send_block('1, 1'b0, 1);
    send_block(64'h0123_4567_89ab_cdef, 1'b1, 0);
    drain();

    // zero rounds: cipher is the identity
    write_reg(REG_CIPHER_MODE, 64'(MODE_CBC_DEC));
    write_reg(REG_BASE_KEY, 64'hFFFF);
    write_reg(REG_ROUND_COUNT, 64'd0);
    write_reg(REG_INIT_VECTOR, '1);
    send_block(64'hFFFF_0000_FFFF_0000, 1'b1, 0);
    send_block(64'h8000_0000_0000_0001, 1'b0, 2);
    drain();

    // mode change in the middle of a message, maximum rounds
    write_reg(REG_CIPHER_MODE, 64'(MODE_CFB_ENC));
    write_reg(REG_ROUND_COUNT, 64'd128);
    send_block(64'hdead_beef_0bad_f00d, 1'b0, 0);
    send_block(64'h0000_ffff_0000_ffff, 1'b0, 0);
    drain();

    // counts beyond the maximum saturate
    write_reg(REG_CIPHER_MODE, 64'(MODE_CFB_DEC));
    write_reg(REG_ROUND_COUNT, 64'd255);
    send_block(64'h1111_2222_3333_4444, 1'b0, 0);
    send_block(64'h5555_6666_7777_8888, 1'b1, 3);
    drain();

    write_reg(REG_CIPHER_MODE, 64'(MODE_CBC_ENC));
    write_reg(REG_BASE_KEY, 64'h8001);
    write_reg(REG_ROUND_COUNT, 64'd1);
    write_reg(REG_INIT_VECTOR, 64'h5555_5555_5555_5555);
    send_block(64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 0);
    send_block(64'h5555_5555_5555_5555, 1'b0, 0);
    drain();

    write_reg(REG_CIPHER_MODE, 64'(MODE_CBC_DEC));
    write_reg(REG_ROUND_COUNT, 64'd200);
    send_block(64'hfedc_ba98_7654_3210, 1'b0, 0);
    send_block(64'h0f0f_f0f0_0f0f_f0f0, 1'b1, 0);
    drain();

    // receiver holds off while blocks keep coming back to back
    write_reg(REG_CIPHER_MODE, 64'(MODE_CBC_ENC));
    write_reg(REG_ROUND_COUNT, 64'd4);
    hold_results = 1'b1;
    for (i = 0; i < 8; i++)
      send_block(random_block(), i == 0, 0);
    drain();

    // random phases, register changes only while idle
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      noise = {$urandom, $urandom};
      if ($urandom_range(0, 9) < 7)
        write_reg(REG_CIPHER_MODE, {noise[63:2], 2'($urandom_range(0, 3))});
      if ($urandom_range(0, 9) < 6) begin
        r = $urandom_range(0, 99);
        key = (r < 10) ? 16'h0000 : (r < 20) ? 16'hFFFF : 16'($urandom);
        write_reg(REG_BASE_KEY, {noise[63:16], key});
      end
      if ($urandom_range(0, 9) < 6) begin
        r = $urandom_range(0, 99);
        if (r < 60)
          rounds = 8'($urandom_range(0, 12));
        else if (r < 85)
          rounds = 8'($urandom_range(13, 99));
        else if (r < 95)
          rounds = 8'($urandom_range(100, 128));
        else
          rounds = 8'($urandom_range(129, 255));
        write_reg(REG_ROUND_COUNT, {noise[63:8], rounds});
      end
      if ($urandom_range(0, 9) < 5)
        write_reg(REG_INIT_VECTOR, random_block());
      phase_len = $urandom_range(20, 80);
      for (i = 0; i < phase_len; i++) begin
        send_block(random_block(), (i == 0) || ($urandom_range(0, 7) == 0), sender_gap());
        sent++;
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/fbc_pkg.sv
sv/fbc_round.sv
sv/feistel4_block_cipher_cbc_cfb.sv
test/fbc_result_check.sv
test/testbench.sv
